FILE: rtl/core/touch_gesture_recognizer_unit_assert.svh
// assertion macros for the touch gesture recognizer
// used by the top level only, no other dependencies
`ifndef TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
// same-cycle implication
`define TGR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch gesture recognizer assertion failed");
// next-cycle implication
`define TGR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch gesture recognizer assertion failed");
`endif

FILE: rtl/core/tgr_pkg.sv
// shared types, codes and constants of the touch gesture recognizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

   localparam int DATA_IN_W  = 72;
   localparam int SQ_W       = 36;
   localparam int DIV_BITS   = 56;
   localparam int SQRT_STEPS = 28;

   localparam logic [3:0] GEST_NONE      = 4'd0;
   localparam logic [3:0] GEST_TAP       = 4'd1;
   localparam logic [3:0] GEST_DOUBLE    = 4'd2;
   localparam logic [3:0] GEST_LONG      = 4'd3;
   localparam logic [3:0] GEST_LEFT      = 4'd4;
   localparam logic [3:0] GEST_RIGHT     = 4'd5;
   localparam logic [3:0] GEST_UP        = 4'd6;
   localparam logic [3:0] GEST_DOWN      = 4'd7;
   localparam logic [3:0] GEST_PINCH_IN  = 4'd8;
   localparam logic [3:0] GEST_PINCH_OUT = 4'd9;
   localparam logic [3:0] GEST_ROTATE    = 4'd10;

   localparam logic [2:0] REG_DTAP_WINDOW = 3'd0;
   localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
   localparam logic [2:0] REG_TAP_RADIUS  = 3'd2;
   localparam logic [2:0] REG_SWIPE_DIST  = 3'd3;
   localparam logic [2:0] REG_PINCH_MARG  = 3'd4;
   localparam logic [2:0] REG_ROT_MARG    = 3'd5;

   localparam logic [15:0] SCALE_ONE = 16'd1024;
   localparam logic [15:0] SCALE_MAX = 16'hFFFF;
   localparam logic signed [25:0] DEG90_Q16 = 26'sd5898240;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_A, ST_SQ_B, ST_RAD_A, ST_RAD_B, ST_DECIDE,
      ST_PN_A, ST_PN_B, ST_PS_A, ST_PS_B, ST_DIV, ST_SQRT,
      ST_CRD_INIT, ST_CRD, ST_FINISH, ST_EMIT
   } tgr_state_type;

   typedef struct packed {
      logic [15:0] double_tap_window_ms;
      logic [15:0] long_press_ms;
      logic [11:0] tap_radius_px;
      logic [11:0] swipe_distance_px;
      logic [15:0] pinch_margin_q10;
      logic [11:0] rotate_margin_q4;
   } tgr_cfg_type;

   typedef struct packed {
      logic               bad;
      logic [3:0]         touch_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               is_down;
      logic [31:0]        time_ms;
   } tgr_item_type;

   typedef struct packed {
      logic         valid;
      tgr_item_type item;
   } tgr_queue_type;

   // arctangent of 2^-i in degrees, 16 fraction bits
   function automatic logic [21:0] atan_q16(input logic [4:0] step);
      logic [21:0] v;
      unique case (step)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tgr_front.sv
// front end: accepts touch events, flags bad indexes, two-entry queue
// depends on tgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgr_front #(
   parameter int MAX_TOUCHES = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // touch_index, pos_x, pos_y, time_ms, zero pad
   input  wire logic [71:0]            req_tdata,
   // is_down
   input  wire logic                   req_tuser,
   output tgr_pkg::tgr_queue_type      head,
   input  wire logic                   pop
);

   tgr_pkg::tgr_item_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   tgr_pkg::tgr_item_type item_in;

   always_comb begin
      item_in.touch_index = req_tdata[3:0];
      item_in.pos_x       = req_tdata[19:4];
      item_in.pos_y       = req_tdata[35:20];
      item_in.time_ms     = req_tdata[67:36];
      item_in.is_down     = req_tuser;
      item_in.bad         = {1'b0, req_tdata[3:0]} >= 5'(MAX_TOUCHES);
   end

   assign req_tready = cnt_ff != 2'd2;
   assign push       = req_tvalid && req_tready;
   assign head.valid = cnt_ff != 2'd0;
   assign head.item  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tgr_back.sv
// back end: sequencer that updates touch state, runs the shared squarer,
// divider, square root and cordic, and drives the result register; uses tgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgr_back #(
   parameter int MAX_TOUCHES  = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  tgr_pkg::tgr_cfg_type        cfg,
   input  tgr_pkg::tgr_queue_type      head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // scale_q10, rotation_q4, zero pad
   output logic [31:0]                 rsp_tdata,
   // status, gesture
   output logic [4:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int IW = $clog2(MAX_TOUCHES);
   localparam logic [5:0] DIV_LAST  = 6'(tgr_pkg::DIV_BITS - 1);
   localparam logic [5:0] SQRT_LAST = 6'(tgr_pkg::SQRT_STEPS - 1);
   localparam logic [4:0] CRD_LAST  = 5'(CORDIC_STEPS - 1);

   tgr_pkg::tgr_state_type state_ff, state_in;

   // event
   logic [3:0]         idx_ff;
   logic signed [15:0] x_ff, y_ff;
   logic               down_ff;
   logic [31:0]        t_ff;
   logic               status_ff;

   // touch state
   logic signed [15:0] now_x_ff [MAX_TOUCHES];
   logic signed [15:0] now_y_ff [MAX_TOUCHES];
   logic signed [15:0] start_x_ff [MAX_TOUCHES];
   logic signed [15:0] start_y_ff [MAX_TOUCHES];
   logic [3:0]         touches_ff;
   logic               active_ff;
   logic [31:0]        gstart_ff;
   logic [31:0]        tprev_ms_ff;
   logic signed [15:0] tprev_x_ff, tprev_y_ff;
   logic [1:0]         trun_ff;
   logic [15:0]        scale_ff;
   logic signed [12:0] rot_ff;

   // arithmetic
   logic [35:0]        acc_ff, snow_ff, sstart_ff, rem_ff;
   logic [23:0]        r2a_ff, r2b_ff;
   logic [55:0]        quo_ff;
   logic [27:0]        root_ff;
   logic [29:0]        srem_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [25:0] cz_ff, a_now_ff;
   logic               zv_ff, sel_ff;
   logic [5:0]         cnt_ff;

   // results
   logic [3:0] g_ff [3];
   logic [1:0] n_ff, k_ff;
   logic       rsp_valid_ff;

   logic [IW-1:0]      slot;
   logic signed [16:0] ev_dx, ev_dy, pn_dx, pn_dy, ps_dx, ps_dy;
   logic signed [16:0] mul_op;
   logic signed [33:0] prod;
   logic [35:0]        prod_u, acc_sum;

   logic [31:0] dt_press, held;
   logic        dbl_hit, rel_hit, pinch_go;
   logic [1:0]  trun_inc;
   logic [3:0]  touches_nx, rel_code;
   logic [16:0] ax, ay;

   logic [36:0] rem_sh;
   logic        div_ge;
   logic [31:0] srem_sh, trial;
   logic        sqrt_ge;

   logic signed [16:0] v_x, v_y;
   logic signed [35:0] vx_ext, vy_ext, cx_sh, cy_sh;
   logic signed [25:0] atan_v, cz_step;

   logic [15:0]        scale_fin, dev;
   logic signed [25:0] a_start;
   logic signed [27:0] rot_sum, rot_sh, rot_w;
   logic signed [12:0] rot_fin;
   logic [12:0]        rot_abs;
   logic               pinch_hit, rot_hit;

   logic [1:0] n_eff;
   logic       emit_load, emit_last;

   assign slot = idx_ff[IW-1:0];

   // differences and the shared squarer
   always_comb begin
      ev_dx = {x_ff[15], x_ff} - (down_ff ? {tprev_x_ff[15], tprev_x_ff}
                                          : {start_x_ff[slot][15], start_x_ff[slot]});
      ev_dy = {y_ff[15], y_ff} - (down_ff ? {tprev_y_ff[15], tprev_y_ff}
                                          : {start_y_ff[slot][15], start_y_ff[slot]});
      pn_dx = {now_x_ff[1][15], now_x_ff[1]} - {now_x_ff[0][15], now_x_ff[0]};
      pn_dy = {now_y_ff[1][15], now_y_ff[1]} - {now_y_ff[0][15], now_y_ff[0]};
      ps_dx = {start_x_ff[1][15], start_x_ff[1]} - {start_x_ff[0][15], start_x_ff[0]};
      ps_dy = {start_y_ff[1][15], start_y_ff[1]} - {start_y_ff[0][15], start_y_ff[0]};
   end

   assign prod    = mul_op * mul_op;
   assign prod_u  = {2'b00, prod};
   assign acc_sum = acc_ff + prod_u;

   // press and release decisions
   always_comb begin
      dt_press = t_ff - tprev_ms_ff;
      held     = t_ff - gstart_ff;
      dbl_hit  = (dt_press < {16'd0, cfg.double_tap_window_ms}) &&
                 (acc_ff < {12'd0, r2a_ff});
      trun_inc = trun_ff + 2'd1;
      if (down_ff) begin
         touches_nx = (touches_ff == 4'd15) ? touches_ff : touches_ff + 4'd1;
      end else begin
         touches_nx = (touches_ff == 4'd0) ? touches_ff : touches_ff - 4'd1;
      end
      ax = ev_dx[16] ? 17'(-ev_dx) : 17'(ev_dx);
      ay = ev_dy[16] ? 17'(-ev_dy) : 17'(ev_dy);
      rel_hit  = 1'b0;
      rel_code = tgr_pkg::GEST_NONE;
      priority if (acc_ff < {12'd0, r2a_ff}) begin
         if (held >= {16'd0, cfg.long_press_ms}) begin
            rel_hit  = 1'b1;
            rel_code = tgr_pkg::GEST_LONG;
         end else if (trun_ff == 2'd1) begin
            rel_hit  = 1'b1;
            rel_code = tgr_pkg::GEST_TAP;
         end
      end else if (acc_ff >= {12'd0, r2b_ff}) begin
         rel_hit = 1'b1;
         if (ax > ay) begin
            rel_code = (ev_dx > 17'sd0) ? tgr_pkg::GEST_RIGHT : tgr_pkg::GEST_LEFT;
         end else begin
            rel_code = (ev_dy > 17'sd0) ? tgr_pkg::GEST_DOWN : tgr_pkg::GEST_UP;
         end
      end else begin
         rel_hit = 1'b0;
      end
      pinch_go = (touches_nx >= 4'd2) && (idx_ff < 4'd2);
   end

   // divider and square root steps
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[55]};
      div_ge  = rem_sh >= {1'b0, sstart_ff};
      srem_sh = {srem_ff, quo_ff[55:54]};
      trial   = {2'b00, root_ff, 2'b01};
      sqrt_ge = srem_sh >= trial;
   end

   // cordic step
   always_comb begin
      v_x     = sel_ff ? ps_dx : pn_dx;
      v_y     = sel_ff ? ps_dy : pn_dy;
      vx_ext  = {{3{v_x[16]}}, v_x, 16'd0};
      vy_ext  = {{3{v_y[16]}}, v_y, 16'd0};
      cx_sh   = cx_ff >>> cnt_ff[4:0];
      cy_sh   = cy_ff >>> cnt_ff[4:0];
      atan_v  = {4'd0, tgr_pkg::atan_q16(cnt_ff[4:0])};
      cz_step = cy_ff[35] ? cz_ff - atan_v : cz_ff + atan_v;
   end

   // scale, rotation and pinch decisions
   always_comb begin
      if (sstart_ff == 36'd0) begin
         scale_fin = (snow_ff == 36'd0) ? tgr_pkg::SCALE_ONE : tgr_pkg::SCALE_MAX;
      end else begin
         scale_fin = (|root_ff[27:16]) ? tgr_pkg::SCALE_MAX : root_ff[15:0];
      end
      dev = (scale_fin > tgr_pkg::SCALE_ONE) ? scale_fin - tgr_pkg::SCALE_ONE
                                             : tgr_pkg::SCALE_ONE - scale_fin;
      a_start = zv_ff ? 26'sd0 : cz_ff;
      rot_sum = {{2{a_now_ff[25]}}, a_now_ff} - {{2{a_start[25]}}, a_start} + 28'sd2048;
      rot_sh  = rot_sum >>> 12;
      if (rot_sh > 28'sd2880) begin
         rot_w = rot_sh - 28'sd5760;
      end else if (rot_sh < -28'sd2880) begin
         rot_w = rot_sh + 28'sd5760;
      end else begin
         rot_w = rot_sh;
      end
      rot_fin   = rot_w[12:0];
      rot_abs   = rot_fin[12] ? 13'(-rot_fin) : 13'(rot_fin);
      pinch_hit = dev > cfg.pinch_margin_q10;
      rot_hit   = rot_abs > {1'b0, cfg.rotate_margin_q4};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tgr_pkg::ST_IDLE: begin
            if (head.valid) begin
               state_in = head.item.bad ? tgr_pkg::ST_EMIT : tgr_pkg::ST_SQ_A;
            end
         end
         tgr_pkg::ST_SQ_A:     state_in = tgr_pkg::ST_SQ_B;
         tgr_pkg::ST_SQ_B:     state_in = tgr_pkg::ST_RAD_A;
         tgr_pkg::ST_RAD_A:    state_in = tgr_pkg::ST_RAD_B;
         tgr_pkg::ST_RAD_B:    state_in = tgr_pkg::ST_DECIDE;
         tgr_pkg::ST_DECIDE:   state_in = pinch_go ? tgr_pkg::ST_PN_A : tgr_pkg::ST_EMIT;
         tgr_pkg::ST_PN_A:     state_in = tgr_pkg::ST_PN_B;
         tgr_pkg::ST_PN_B:     state_in = tgr_pkg::ST_PS_A;
         tgr_pkg::ST_PS_A:     state_in = tgr_pkg::ST_PS_B;
         tgr_pkg::ST_PS_B:     state_in = tgr_pkg::ST_DIV;
         tgr_pkg::ST_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = tgr_pkg::ST_SQRT;
         end
         tgr_pkg::ST_SQRT: begin
            if (cnt_ff == SQRT_LAST) state_in = tgr_pkg::ST_CRD_INIT;
         end
         tgr_pkg::ST_CRD_INIT: state_in = tgr_pkg::ST_CRD;
         tgr_pkg::ST_CRD: begin
            if (cnt_ff[4:0] == CRD_LAST) begin
               state_in = sel_ff ? tgr_pkg::ST_FINISH : tgr_pkg::ST_CRD_INIT;
            end
         end
         tgr_pkg::ST_FINISH:   state_in = tgr_pkg::ST_EMIT;
         tgr_pkg::ST_EMIT: begin
            if (emit_load && emit_last) state_in = tgr_pkg::ST_IDLE;
         end
         default:              state_in = tgr_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop       = (state_ff == tgr_pkg::ST_IDLE) && head.valid;
      n_eff     = (n_ff == 2'd0) ? 2'd1 : n_ff;
      emit_load = (state_ff == tgr_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);
      emit_last = k_ff == (n_eff - 2'd1);
      unique case (state_ff)
         tgr_pkg::ST_SQ_A:  mul_op = ev_dx;
         tgr_pkg::ST_SQ_B:  mul_op = ev_dy;
         tgr_pkg::ST_RAD_A: mul_op = {5'd0, cfg.tap_radius_px};
         tgr_pkg::ST_RAD_B: mul_op = {5'd0, cfg.swipe_distance_px};
         tgr_pkg::ST_PN_A:  mul_op = pn_dx;
         tgr_pkg::ST_PN_B:  mul_op = pn_dy;
         tgr_pkg::ST_PS_A:  mul_op = ps_dx;
         tgr_pkg::ST_PS_B:  mul_op = ps_dy;
         default:           mul_op = 17'sd0;
      endcase
   end

   // control and reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tgr_pkg::ST_IDLE;
         touches_ff   <= 4'd0;
         active_ff    <= 1'b0;
         gstart_ff    <= 32'd0;
         tprev_ms_ff  <= 32'd0;
         tprev_x_ff   <= 16'sd0;
         tprev_y_ff   <= 16'sd0;
         trun_ff      <= 2'd0;
         scale_ff     <= tgr_pkg::SCALE_ONE;
         rot_ff       <= 13'sd0;
         n_ff         <= 2'd0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TOUCHES; i++) begin
            now_x_ff[i] <= 16'sd0;
            now_y_ff[i] <= 16'sd0;
         end
      end else begin
         state_ff <= state_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            tgr_pkg::ST_IDLE: begin
               n_ff <= 2'd0;
               k_ff <= 2'd0;
            end
            tgr_pkg::ST_DECIDE: begin
               now_x_ff[slot] <= x_ff;
               now_y_ff[slot] <= y_ff;
               touches_ff     <= touches_nx;
               if (down_ff) begin
                  if (!active_ff) begin
                     active_ff <= 1'b1;
                     gstart_ff <= t_ff;
                     scale_ff  <= tgr_pkg::SCALE_ONE;
                     rot_ff    <= 13'sd0;
                  end
                  if (dbl_hit) begin
                     if (trun_inc == 2'd2) begin
                        trun_ff <= 2'd0;
                        n_ff    <= n_ff + 2'd1;
                     end else begin
                        trun_ff <= trun_inc;
                     end
                  end else begin
                     trun_ff <= 2'd1;
                  end
                  tprev_ms_ff <= t_ff;
                  tprev_x_ff  <= x_ff;
                  tprev_y_ff  <= y_ff;
               end else begin
                  if (rel_hit) n_ff <= n_ff + 2'd1;
                  // all touches lifted: drop the gesture, keep tap history
                  if (touches_nx == 4'd0) begin
                     active_ff <= 1'b0;
                     gstart_ff <= 32'd0;
                     scale_ff  <= tgr_pkg::SCALE_ONE;
                     rot_ff    <= 13'sd0;
                     for (int i = 0; i < MAX_TOUCHES; i++) begin
                        now_x_ff[i] <= 16'sd0;
                        now_y_ff[i] <= 16'sd0;
                     end
                  end
               end
            end
            tgr_pkg::ST_FINISH: begin
               scale_ff <= scale_fin;
               rot_ff   <= rot_fin;
               n_ff     <= n_ff + {1'b0, pinch_hit} + {1'b0, rot_hit};
            end
            tgr_pkg::ST_EMIT: begin
               if (emit_load) k_ff <= k_ff + 2'd1;
            end
            default: begin
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (pop) begin
         idx_ff    <= head.item.touch_index;
         x_ff      <= head.item.pos_x;
         y_ff      <= head.item.pos_y;
         down_ff   <= head.item.is_down;
         t_ff      <= head.item.time_ms;
         status_ff <= head.item.bad;
      end
      unique case (state_ff)
         tgr_pkg::ST_SQ_A:  acc_ff <= prod_u;
         tgr_pkg::ST_SQ_B:  acc_ff <= acc_sum;
         tgr_pkg::ST_RAD_A: r2a_ff <= prod_u[23:0];
         tgr_pkg::ST_RAD_B: r2b_ff <= prod_u[23:0];
         tgr_pkg::ST_DECIDE: begin
            if (down_ff) begin
               start_x_ff[slot] <= x_ff;
               start_y_ff[slot] <= y_ff;
               if (dbl_hit && (trun_inc == 2'd2)) g_ff[n_ff] <= tgr_pkg::GEST_DOUBLE;
            end else if (rel_hit) begin
               g_ff[n_ff] <= rel_code;
            end
         end
         tgr_pkg::ST_PN_A: acc_ff  <= prod_u;
         tgr_pkg::ST_PN_B: snow_ff <= acc_sum;
         tgr_pkg::ST_PS_A: acc_ff  <= prod_u;
         tgr_pkg::ST_PS_B: begin
            sstart_ff <= acc_sum;
            quo_ff    <= {snow_ff, 20'd0};
            rem_ff    <= 36'd0;
            cnt_ff    <= 6'd0;
         end
         tgr_pkg::ST_DIV: begin
            rem_ff <= div_ge ? 36'(rem_sh - {1'b0, sstart_ff}) : rem_sh[35:0];
            quo_ff <= {quo_ff[54:0], div_ge};
            if (cnt_ff == DIV_LAST) begin
               cnt_ff  <= 6'd0;
               root_ff <= 28'd0;
               srem_ff <= 30'd0;
            end else begin
               cnt_ff <= cnt_ff + 6'd1;
            end
         end
         tgr_pkg::ST_SQRT: begin
            srem_ff <= sqrt_ge ? 30'(srem_sh - trial) : srem_sh[29:0];
            root_ff <= {root_ff[26:0], sqrt_ge};
            quo_ff  <= {quo_ff[53:0], 2'b00};
            if (cnt_ff == SQRT_LAST) begin
               sel_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         tgr_pkg::ST_CRD_INIT: begin
            cnt_ff <= 6'd0;
            zv_ff  <= (v_x == 17'sd0) && (v_y == 17'sd0);
            // left half plane is turned by a quarter first
            if (vx_ext[35]) begin
               if (!vy_ext[35]) begin
                  cx_ff <= vy_ext;
                  cy_ff <= -vx_ext;
                  cz_ff <= tgr_pkg::DEG90_Q16;
               end else begin
                  cx_ff <= -vy_ext;
                  cy_ff <= vx_ext;
                  cz_ff <= -tgr_pkg::DEG90_Q16;
               end
            end else begin
               cx_ff <= vx_ext;
               cy_ff <= vy_ext;
               cz_ff <= 26'sd0;
            end
         end
         tgr_pkg::ST_CRD: begin
            if (cy_ff[35]) begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
            end else begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
            end
            cz_ff  <= cz_step;
            cnt_ff <= cnt_ff + 6'd1;
            if ((cnt_ff[4:0] == CRD_LAST) && !sel_ff) begin
               a_now_ff <= zv_ff ? 26'sd0 : cz_step;
               sel_ff   <= 1'b1;
            end
         end
         tgr_pkg::ST_FINISH: begin
            if (pinch_hit) begin
               g_ff[n_ff] <= (scale_fin > tgr_pkg::SCALE_ONE) ? tgr_pkg::GEST_PINCH_OUT
                                                            : tgr_pkg::GEST_PINCH_IN;
            end
            if (rot_hit) g_ff[n_ff + {1'b0, pinch_hit}] <= tgr_pkg::GEST_ROTATE;
         end
         default: begin
         end
      endcase
      if (emit_load) begin
         rsp_tdata <= {3'd0, rot_ff, scale_ff};
         rsp_tuser <= {(n_ff == 2'd0) ? tgr_pkg::GEST_NONE : g_ff[k_ff], status_ff};
         rsp_tlast <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/touch_gesture_recognizer_unit.sv
// touch gesture recognizer: touch events in on req_, gesture results out on
// rsp_, an apb-style register port on csr_.
// each accepted req_ transaction is one press or release event. it produces one
// to three rsp_ transactions, the final one with rsp_tlast set. an event whose
// index is at or above MAX_TOUCHES gives one result with status set.
// events are queued two deep in the front end and handled one at a time by the
// back-end sequencer. a plain press or release squares its displacement and the
// tap and swipe radii, then decides; while two or more touches are down an
// event on touch 0 or 1 also squares both pair distances and runs the 56-step
// divider, the 28-step square root and the cordic twice.
// the result register lets the next event start while a result waits.
// if rsp_tready is low the sequencer holds its last result and the queue
// fills, then req_tready drops. reset is synchronous: it empties the queue,
// clears touch state other than the start positions and loads register
// defaults; no clearing pass is needed. the user must write registers only
// while no event is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_gesture_recognizer_unit_assert.svh"

module touch_gesture_recognizer_unit #(
   parameter int MAX_TOUCHES  = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // touch_index [3:0], pos_x [19:4], pos_y [35:20], time_ms [67:36]
   input  wire logic [71:0] req_tdata,
   // is_down
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // scale_q10 [15:0], rotation_q4 [28:16]
   output logic [31:0]      rsp_tdata,
   // status [0], gesture [4:1]
   output logic [4:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   tgr_pkg::tgr_cfg_type   cfg_ff;
   tgr_pkg::tgr_queue_type head;
   logic                   pop;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_tap_window_ms <= 16'd300;
         cfg_ff.long_press_ms        <= 16'd500;
         cfg_ff.tap_radius_px        <= 12'd10;
         cfg_ff.swipe_distance_px    <= 12'd50;
         cfg_ff.pinch_margin_q10     <= 16'd102;
         cfg_ff.rotate_margin_q4     <= 12'd80;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            tgr_pkg::REG_DTAP_WINDOW: cfg_ff.double_tap_window_ms <= csr_pwdata[15:0];
            tgr_pkg::REG_LONG_PRESS:  cfg_ff.long_press_ms        <= csr_pwdata[15:0];
            tgr_pkg::REG_TAP_RADIUS:  cfg_ff.tap_radius_px        <= csr_pwdata[11:0];
            tgr_pkg::REG_SWIPE_DIST:  cfg_ff.swipe_distance_px    <= csr_pwdata[11:0];
            tgr_pkg::REG_PINCH_MARG:  cfg_ff.pinch_margin_q10     <= csr_pwdata[15:0];
            tgr_pkg::REG_ROT_MARG:    cfg_ff.rotate_margin_q4     <= csr_pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         tgr_pkg::REG_DTAP_WINDOW: csr_prdata = {16'd0, cfg_ff.double_tap_window_ms};
         tgr_pkg::REG_LONG_PRESS:  csr_prdata = {16'd0, cfg_ff.long_press_ms};
         tgr_pkg::REG_TAP_RADIUS:  csr_prdata = {20'd0, cfg_ff.tap_radius_px};
         tgr_pkg::REG_SWIPE_DIST:  csr_prdata = {20'd0, cfg_ff.swipe_distance_px};
         tgr_pkg::REG_PINCH_MARG:  csr_prdata = {16'd0, cfg_ff.pinch_margin_q10};
         tgr_pkg::REG_ROT_MARG:    csr_prdata = {20'd0, cfg_ff.rotate_margin_q4};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   tgr_front #(
      .MAX_TOUCHES (MAX_TOUCHES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   tgr_back #(
      .MAX_TOUCHES  (MAX_TOUCHES),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // an error result stands alone and carries no gesture
   `TGR_ASSERT_IMP(a_err_single, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `TGR_ASSERT_IMP(a_err_none, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tuser[4:1] == tgr_pkg::GEST_NONE)
   // rotation stays wrapped
   `TGR_ASSERT_IMP(a_rot_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[28:16]) <= 13'sd2880) && ($signed(rsp_tdata[28:16]) >= -13'sd2880))
   // the queue only hands out items it holds
   `TGR_ASSERT_IMP(a_pop_valid, clock, reset, pop, head.valid)

endmodule

`default_nettype wire

FILE: test/touch_gesture_recognizer_unit_test.sv
// testbench for the touch gesture recognizer: directed table then random touch sequences,
// every result checked against a predictor of the block kept in this file or, for typed rows,
// against the table row; depends on tgr_pkg and touch_gesture_recognizer_unit
`timescale 1ns / 1ps

module touch_gesture_recognizer_unit_test;

   localparam int TOUCH_LIMIT = 10;
   localparam int ANGLE_STEPS = 16;
   localparam longint QUARTER_TURN_Q16 = 64'sd5898240;
   localparam longint ATAN_DEG_Q16 [16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [3:0]         touch_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               is_down;
      logic [31:0]        time_ms;
   } touch_event_type;

   typedef struct {
      logic               status;
      logic [3:0]         gesture;
      logic [15:0]        scale_q10;
      logic signed [12:0] rotation_q4;
      logic               last;
   } gesture_result_type;

   typedef struct {
      touch_event_type ev;
      bit              typed;
      logic            status;
      logic [3:0]      gesture;
   } table_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   touch_gesture_recognizer_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   tgr_pkg::tgr_cfg_type cfg;
   logic signed [15:0] start_x [TOUCH_LIMIT];
   logic signed [15:0] start_y [TOUCH_LIMIT];
   logic signed [15:0] cur_x [TOUCH_LIMIT];
   logic signed [15:0] cur_y [TOUCH_LIMIT];
   bit [TOUCH_LIMIT-1:0] pressed_mask;
   int                 down_count;
   bit                 in_gesture;
   logic [31:0]        gesture_t0;
   logic [31:0]        last_tap_ms;
   logic signed [15:0] last_tap_x, last_tap_y;
   int                 tap_count;
   logic [15:0]        scale_q10;
   logic signed [12:0] rotation_q4;

   gesture_result_type expected_results[$];
   int error_count = 0;
   int result_count = 0;
   int event_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit pressure_armed = 0;
   int hold_left = 0;
   longint unsigned gesture_hits[16];

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      error_count++;
   endtask

   function automatic void clear_touches();
      for (int i = 0; i < TOUCH_LIMIT; i++) begin
         start_x[i] = 0; start_y[i] = 0; cur_x[i] = 0; cur_y[i] = 0;
      end
      pressed_mask = '0;
      down_count = 0;
      in_gesture = 0;
      gesture_t0 = 0;
      scale_q10 = tgr_pkg::SCALE_ONE;
      rotation_q4 = 0;
   endfunction

   function automatic longint unsigned dist_sq(longint x0, longint y0, longint x1, longint y1);
      return (x1 - x0) * (x1 - x0) + (y1 - y0) * (y1 - y0);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN_Q16;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN_Q16;
         end
      end
      for (int i = 0; i < ANGLE_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_DEG_Q16[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_DEG_Q16[i];
         end
      end
      return z;
   endfunction

   // works out the results of one accepted event and queues them
   function automatic void predict_gestures(touch_event_type ev);
      logic [3:0]         found[$];
      gesture_result_type r;
      longint unsigned    tap_r2, d2, s_now, s_start, sc;
      longint             dx, dy, ax, ay, a_now, a_start, rot, dev;
      logic [31:0]        held;
      int                 i;
      bit                 bad;
      bad = ev.touch_index >= TOUCH_LIMIT;
      tap_r2 = longint'(cfg.tap_radius_px) * cfg.tap_radius_px;
      i = ev.touch_index;
      if (!bad) begin
         cur_x[i] = ev.pos_x;
         cur_y[i] = ev.pos_y;
         if (ev.is_down) begin
            start_x[i] = ev.pos_x;
            start_y[i] = ev.pos_y;
            pressed_mask[i] = 1;
            if (down_count < 15) down_count++;
            if (!in_gesture) begin
               in_gesture = 1;
               gesture_t0 = ev.time_ms;
               scale_q10 = tgr_pkg::SCALE_ONE;
               rotation_q4 = 0;
            end
            if (32'(ev.time_ms - last_tap_ms) < cfg.double_tap_window_ms &&
                dist_sq(ev.pos_x, ev.pos_y, last_tap_x, last_tap_y) < tap_r2) begin
               tap_count++;
               if (tap_count == 2) begin
                  found.push_back(tgr_pkg::GEST_DOUBLE);
                  tap_count = 0;
               end
            end else begin
               tap_count = 1;
            end
            last_tap_ms = ev.time_ms;
            last_tap_x = ev.pos_x;
            last_tap_y = ev.pos_y;
         end else begin
            dx = longint'(ev.pos_x) - start_x[i];
            dy = longint'(ev.pos_y) - start_y[i];
            d2 = dist_sq(start_x[i], start_y[i], ev.pos_x, ev.pos_y);
            held = ev.time_ms - gesture_t0;
            if (down_count > 0) down_count--;
            if (d2 < tap_r2) begin
               if (held >= cfg.long_press_ms) found.push_back(tgr_pkg::GEST_LONG);
               else if (tap_count == 1) found.push_back(tgr_pkg::GEST_TAP);
            end else if (d2 >= longint'(cfg.swipe_distance_px) * cfg.swipe_distance_px) begin
               ax = dx < 0 ? -dx : dx;
               ay = dy < 0 ? -dy : dy;
               if (ax > ay) found.push_back(dx > 0 ? tgr_pkg::GEST_RIGHT : tgr_pkg::GEST_LEFT);
               else found.push_back(dy > 0 ? tgr_pkg::GEST_DOWN : tgr_pkg::GEST_UP);
            end
            if (down_count == 0) clear_touches();
         end
         if (down_count >= 2 && i < 2) begin
            s_now = dist_sq(cur_x[0], cur_y[0], cur_x[1], cur_y[1]);
            s_start = dist_sq(start_x[0], start_y[0], start_x[1], start_y[1]);
            a_now = vector_angle(longint'(cur_x[1]) - cur_x[0], longint'(cur_y[1]) - cur_y[0]);
            a_start = vector_angle(longint'(start_x[1]) - start_x[0],
                                   longint'(start_y[1]) - start_y[0]);
            if (s_start == 0) begin
               scale_q10 = s_now == 0 ? tgr_pkg::SCALE_ONE : tgr_pkg::SCALE_MAX;
            end else begin
               sc = int_sqrt((s_now << 20) / s_start);
               scale_q10 = sc > 65535 ? tgr_pkg::SCALE_MAX : sc[15:0];
            end
            rot = (a_now - a_start + 2048) >>> 12;
            if (rot > 2880) rot -= 5760;
            if (rot < -2880) rot += 5760;
            rotation_q4 = rot[12:0];
            dev = longint'(scale_q10) - 1024;
            if (dev < 0) dev = -dev;
            if (dev > cfg.pinch_margin_q10 && found.size() < 3)
               found.push_back(scale_q10 > tgr_pkg::SCALE_ONE ? tgr_pkg::GEST_PINCH_OUT
                                                              : tgr_pkg::GEST_PINCH_IN);
            rot = rotation_q4;
            if ((rot < 0 ? -rot : rot) > cfg.rotate_margin_q4 && found.size() < 3)
               found.push_back(tgr_pkg::GEST_ROTATE);
         end
      end
      if (found.size() == 0) found.push_back(tgr_pkg::GEST_NONE);
      foreach (found[k]) begin
         r.status = bad;
         r.gesture = found[k];
         r.scale_q10 = scale_q10;
         r.rotation_q4 = rotation_q4;
         r.last = k == found.size() - 1;
         expected_results.push_back(r);
         gesture_hits[found[k]]++;
      end
   endfunction

   // keeps the stream inside the contract: no release of a touch not pressed since
   // all were last lifted, no two-finger math on touch 0 or 1 before both were pressed
   function automatic void make_legal(ref touch_event_type ev);
      bit [TOUCH_LIMIT-1:0] m;
      int td;
      if (ev.touch_index >= TOUCH_LIMIT) return;
      if (!ev.is_down && !pressed_mask[ev.touch_index]) ev.is_down = 1;
      m = pressed_mask;
      if (ev.is_down) begin
         m[ev.touch_index] = 1;
         td = down_count < 15 ? down_count + 1 : 15;
      end else begin
         td = down_count - 1;
      end
      if (td >= 2 && ev.touch_index < 2 && !(m[0] && m[1])) begin
         ev.touch_index = 4'($urandom_range(9, 2));
         ev.is_down = 1;
      end
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         tgr_pkg::REG_DTAP_WINDOW: cfg.double_tap_window_ms = val[15:0];
         tgr_pkg::REG_LONG_PRESS:  cfg.long_press_ms = val[15:0];
         tgr_pkg::REG_TAP_RADIUS:  cfg.tap_radius_px = val[11:0];
         tgr_pkg::REG_SWIPE_DIST:  cfg.swipe_distance_px = val[11:0];
         tgr_pkg::REG_PINCH_MARG:  cfg.pinch_margin_q10 = val[15:0];
         default:                  cfg.rotate_margin_q4 = val[11:0];
      endcase
   endtask

   task automatic apply_settings(int dtap, int longp, int tapr, int swipe, int pinch, int rot);
      csr_write(tgr_pkg::REG_DTAP_WINDOW, 32'(dtap));
      csr_write(tgr_pkg::REG_LONG_PRESS, 32'(longp));
      csr_write(tgr_pkg::REG_TAP_RADIUS, 32'(tapr));
      csr_write(tgr_pkg::REG_SWIPE_DIST, 32'(swipe));
      csr_write(tgr_pkg::REG_PINCH_MARG, 32'(pinch));
      csr_write(tgr_pkg::REG_ROT_MARG, 32'(rot));
   endtask

   task automatic send_event(touch_event_type ev, bit legalize);
      if (legalize) make_legal(ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, ev.time_ms, ev.pos_y, ev.pos_x, ev.touch_index};
      req_tuser <= ev.is_down;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_gestures(ev);
      event_count++;
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      gesture_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, gesture", -1, rsp_tuser[4:1]);
         end else begin
            e = expected_results.pop_front();
            if (rsp_tuser[0] !== e.status) report_mismatch("status", e.status, rsp_tuser[0]);
            if (rsp_tuser[4:1] !== e.gesture)
               report_mismatch("gesture", e.gesture, rsp_tuser[4:1]);
            if (rsp_tdata[15:0] !== e.scale_q10)
               report_mismatch("scale_q10", e.scale_q10, rsp_tdata[15:0]);
            if (rsp_tdata[28:16] !== e.rotation_q4)
               report_mismatch("rotation_q4", e.rotation_q4, $signed(rsp_tdata[28:16]));
            if (rsp_tlast !== e.last) report_mismatch("last", e.last, rsp_tlast);
         end
      end
   end

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (pressure_armed) begin
         pressure_armed = 0;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic signed [15:0] near(logic signed [15:0] c, int span);
      return 16'(int'(c) + $signed($urandom_range(2 * span)) - span);
   endfunction

   // one random touch sequence, mostly well formed
   task automatic queue_sequence(ref touch_event_type seq[$], ref logic [31:0] now_ms);
      touch_event_type ev;
      logic signed [15:0] cx, cy;
      int kind, id, n;
      kind = $urandom_range(9);
      id = $urandom_range(TOUCH_LIMIT - 1);
      cx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(4000)) - 2000);
      cy = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(4000)) - 2000);
      if ($urandom_range(19) == 0) now_ms = $urandom;
      now_ms += $urandom_range(900, 1);
      ev.touch_index = 4'(id);
      ev.time_ms = now_ms;
      case (kind)
         0, 1: begin // tap or double tap
            n = kind + 1;
            repeat (n) begin
               ev.is_down = 1; ev.pos_x = near(cx, 6); ev.pos_y = near(cy, 6);
               seq.push_back(ev);
               ev.time_ms += $urandom_range(250); ev.is_down = 0;
               ev.pos_x = near(cx, 6); ev.pos_y = near(cy, 6);
               seq.push_back(ev);
               ev.time_ms += $urandom_range(200);
            end
            now_ms = ev.time_ms;
         end
         2, 3: begin // swipe or long press
            ev.is_down = 1; ev.pos_x = cx; ev.pos_y = cy;
            seq.push_back(ev);
            ev.is_down = 0;
            ev.time_ms += $urandom_range(1200);
            ev.pos_x = near(cx, kind == 2 ? 300 : 8);
            ev.pos_y = near(cy, kind == 2 ? 300 : 8);
            seq.push_back(ev);
            now_ms = ev.time_ms;
         end
         4, 5, 6: begin // three fingers down, touch 0 or 1 moved by presses and releases with others down
            for (int k = 0; k < 3; k++) begin
               ev.touch_index = 4'(k); ev.is_down = 1;
               ev.pos_x = near(cx, 400); ev.pos_y = near(cy, 400);
               seq.push_back(ev);
            end
            repeat ($urandom_range(3, 1)) begin
               ev.touch_index = 4'($urandom_range(1)); ev.is_down = 1'($urandom_range(1));
               ev.pos_x = near(cx, 600); ev.pos_y = near(cy, 600);
               seq.push_back(ev);
               if (!ev.is_down) begin
                  ev.is_down = 1; ev.touch_index = 4'(3 + $urandom_range(6));
                  seq.push_back(ev);
               end
            end
            for (int k = 0; k < TOUCH_LIMIT; k++) begin
               ev.touch_index = 4'(k); ev.is_down = 0;
               ev.pos_x = near(cx, 600); ev.pos_y = near(cy, 600);
               if ($urandom_range(3) != 0) seq.push_back(ev);
            end
         end
         7: begin // pile of presses to saturate the count
            repeat (16) begin
               ev.touch_index = 4'($urandom_range(TOUCH_LIMIT - 1)); ev.is_down = 1;
               ev.pos_x = 16'($urandom); ev.pos_y = 16'($urandom);
               seq.push_back(ev);
            end
         end
         default: begin // noise
            repeat (4) begin
               ev.touch_index = 4'($urandom_range(15)); ev.is_down = 1'($urandom_range(1));
               ev.pos_x = 16'($urandom); ev.pos_y = 16'($urandom); ev.time_ms = $urandom;
               seq.push_back(ev);
            end
         end
      endcase
   endtask

   table_row_type directed[$];
   touch_event_type pending[$];
   logic [31:0] clock_ms;
   int directed_errors;

   function automatic table_row_type row(int idx, int x, int y, bit dn, logic [31:0] t,
                                         bit typed = 0, logic st = 0,
                                         logic [3:0] g = tgr_pkg::GEST_NONE);
      table_row_type r;
      r.ev.touch_index = 4'(idx); r.ev.pos_x = 16'(x); r.ev.pos_y = 16'(y);
      r.ev.is_down = dn; r.ev.time_ms = t;
      r.typed = typed; r.status = st; r.gesture = g;
      return r;
   endfunction

   initial begin
      gesture_result_type typed_result;
      clear_touches();
      last_tap_ms = 0; last_tap_x = 0; last_tap_y = 0; tap_count = 0;
      cfg.double_tap_window_ms = 300; cfg.long_press_ms = 500; cfg.tap_radius_px = 10;
      cfg.swipe_distance_px = 50; cfg.pinch_margin_q10 = 102; cfg.rotate_margin_q4 = 80;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed.push_back(row(15, 32767, -32768, 1, 0, 1, 1, tgr_pkg::GEST_NONE));
      directed.push_back(row(0, 0, 0, 1, 1000, 1, 0, tgr_pkg::GEST_NONE));
      directed.push_back(row(0, 2, 2, 0, 1100, 1, 0, tgr_pkg::GEST_TAP));
      directed.push_back(row(0, 1, 1, 1, 1200, 1, 0, tgr_pkg::GEST_DOUBLE));
      directed.push_back(row(0, 1, 1, 0, 1250));
      directed.push_back(row(3, 100, 100, 1, 5000));
      directed.push_back(row(3, 100, 100, 0, 6000, 1, 0, tgr_pkg::GEST_LONG));
      directed.push_back(row(4, 0, 0, 1, 7000));
      directed.push_back(row(4, -200, 10, 0, 7100));
      directed.push_back(row(5, 0, 0, 1, 8000));
      directed.push_back(row(5, 200, 0, 0, 8100));
      directed.push_back(row(6, -32768, -32768, 1, 9000));
      directed.push_back(row(6, -32768, 32767, 0, 9100));
      directed.push_back(row(7, 32767, 32767, 1, 32'hFFFF_FFF0));
      directed.push_back(row(7, 32767, -32768, 0, 32'h0000_0040));
      // zero start distance, then current distance grows
      directed.push_back(row(0, 5, 5, 1, 20000));
      directed.push_back(row(1, 5, 5, 1, 20001));
      directed.push_back(row(2, 0, 0, 1, 20002));
      directed.push_back(row(0, 9, 5, 0, 20003));
      directed.push_back(row(1, 5, 5, 0, 20004));
      directed.push_back(row(2, 0, 0, 0, 20005));
      // pinch in plus rotate, then pinch out plus rotate
      directed.push_back(row(0, -100, 0, 1, 30000));
      directed.push_back(row(1, 100, 0, 1, 30010));
      directed.push_back(row(2, 0, 0, 1, 30020));
      directed.push_back(row(3, 9, 9, 1, 30030));
      directed.push_back(row(0, 100, -100, 0, 30040));
      directed.push_back(row(1, 100, 400, 0, 30050));
      directed.push_back(row(2, 0, 0, 0, 30060));
      directed.push_back(row(3, 9, 9, 0, 30070));

      foreach (directed[k]) begin
         send_event(directed[k].ev, 0);
         if (directed[k].typed) begin
            void'(expected_results.pop_back());
            typed_result.status = directed[k].status;
            typed_result.gesture = directed[k].gesture;
            typed_result.scale_q10 = tgr_pkg::SCALE_ONE;
            typed_result.rotation_q4 = 0;
            typed_result.last = 1;
            expected_results.push_back(typed_result);
         end
      end
      drain_results();

      clock_ms = 100000;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: apply_settings(0, 0, 0, 0, 0, 0);
            1: apply_settings(65535, 65535, 4095, 4095, 65535, 2880);
            2: apply_settings(300, 500, 10, 50, 102, 80);
            default: apply_settings($urandom_range(65535), $urandom_range(65535),
                                    $urandom_range(4095), $urandom_range(4095),
                                    $urandom_range(65535), $urandom_range(2880));
         endcase
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 32) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 32) : 0;
         if (ph == 0) pressure_armed = 1;
         pending.delete();
         while (pending.size() < 85) queue_sequence(pending, clock_ms);
         foreach (pending[k]) send_event(pending[k], 1);
         drain_results();
      end

      $display("%0d touch events sent, %0d results checked under four register settings",
               event_count, result_count);
      $display("taps %0d, double %0d, long %0d, swipes %0d, pinches %0d, rotates %0d",
               gesture_hits[tgr_pkg::GEST_TAP], gesture_hits[tgr_pkg::GEST_DOUBLE],
               gesture_hits[tgr_pkg::GEST_LONG],
               gesture_hits[tgr_pkg::GEST_LEFT] + gesture_hits[tgr_pkg::GEST_RIGHT] +
               gesture_hits[tgr_pkg::GEST_UP] + gesture_hits[tgr_pkg::GEST_DOWN],
               gesture_hits[tgr_pkg::GEST_PINCH_IN] + gesture_hits[tgr_pkg::GEST_PINCH_OUT],
               gesture_hits[tgr_pkg::GEST_ROTATE]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: touch_gesture_recognizer_unit.f
+incdir+rtl/core
rtl/core/tgr_pkg.sv
rtl/core/tgr_front.sv
rtl/core/tgr_back.sv
rtl/core/touch_gesture_recognizer_unit.sv
test/touch_gesture_recognizer_unit_test.sv
